// ===== hdl/asac_pkg.sv =====
// ----------------------------------------------------------------------------
// asac_pkg
// Types and constants shared by the section arming controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package asac_pkg;

  // Stream and configuration port widths
  localparam int TDATA_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int ZONE_W    = 6;
  localparam int SRC_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_DELAY = 1'd1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ZONE   = 2'd1,
    CMD_ARM    = 2'd2,
    CMD_DISARM = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REACT_NONE    = 2'd0,
    REACT_DELAY   = 2'd1,
    REACT_INSTANT = 2'd2,
    REACT_24H     = 2'd3
  } react_t;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_UNSET   = 2'd1,
    MODE_SET     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_UNSET = 2'd1,
    EV_SET   = 2'd2,
    EV_ALARM = 2'd3
  } event_t;

  // One input beat, split into fields
  typedef struct packed {
    logic [SRC_W-1:0]  access_source;
    react_t            reaction;
    logic [ZONE_W-1:0] zone;
    cmd_t              cmd;
  } in_item_t;

  // One result beat, split into fields
  typedef struct packed {
    logic              entry_delay_active;
    logic              exit_delay_active;
    logic              alarm_active;
    mode_t             mode;
    logic              may_alarm;
    logic              mode_changed;
    logic [ZONE_W-1:0] event_source;
    event_t            event_kind;
  } out_item_t;

  // Configuration write bundle
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage : asac_pkg

`default_nettype wire

// ===== hdl/asac_core.sv =====
// ----------------------------------------------------------------------------
// asac_core
// Section state, delay registers and the single-step update for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_core #(
  parameter int ZONE_COUNT = 64,
  parameter int DELAY_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire asac_pkg::cfg_wr_t   cfg,
  input  wire logic                step,
  input  wire asac_pkg::in_item_t  item,
  output asac_pkg::out_item_t      result
);
  import asac_pkg::*;

  localparam int CNT_W = DELAY_BITS + 1;

  logic [DELAY_BITS-1:0] exit_delay;
  logic [DELAY_BITS-1:0] entry_delay;

  mode_t             section_mode, section_mode_next;
  logic              alarm_flag, alarm_flag_next;
  logic              exit_flag, exit_flag_next;
  logic              entry_flag, entry_flag_next;
  logic [CNT_W-1:0]  countdown, countdown_next;
  logic [ZONE_W-1:0] pending_zone, pending_zone_next;

  event_t            ev_kind;
  logic [ZONE_W-1:0] ev_src;
  logic              changed;
  logic              may_alarm;
  logic              zone_ok;

  // Delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exit_delay  <= DELAY_BITS'(30);
      entry_delay <= DELAY_BITS'(30);
    end else if (cfg.we) begin
      case (cfg.index)
        REG_EXIT_DELAY:  exit_delay  <= DELAY_BITS'(cfg.data);
        REG_ENTRY_DELAY: entry_delay <= DELAY_BITS'(cfg.data);
        default: ;
      endcase
    end
  end

  assign zone_ok = 32'(item.zone) < 32'(ZONE_COUNT);

  // Reaction check against the mode held before the step
  always_comb begin
    case (section_mode)
      MODE_UNSET: may_alarm = (item.reaction == REACT_24H);
      MODE_SET:   may_alarm = (item.reaction != REACT_NONE);
      default:    may_alarm = 1'b0;
    endcase
  end

  // One step of the section
  always_comb begin
    section_mode_next = section_mode;
    alarm_flag_next   = alarm_flag;
    exit_flag_next    = exit_flag;
    entry_flag_next   = entry_flag;
    countdown_next    = countdown;
    pending_zone_next = pending_zone;
    ev_kind           = EV_NONE;
    ev_src            = '0;
    changed           = 1'b0;

    case (item.cmd)
      CMD_TICK: begin
        if (countdown != '0) begin
          countdown_next = countdown - CNT_W'(1);
          // expiry: end exit delay, fire the delayed alarm if an entry delay is pending
          if (countdown == CNT_W'(1)) begin
            exit_flag_next = 1'b0;
            if (entry_flag) begin
              alarm_flag_next = 1'b1;
              ev_kind         = EV_ALARM;
              ev_src          = pending_zone;
              entry_flag_next = 1'b0;
            end
          end
        end
      end
      CMD_ZONE: begin
        if (zone_ok) begin
          if (section_mode == MODE_SET) begin
            if (item.reaction == REACT_DELAY) begin
              if (countdown == '0) begin
                pending_zone_next = item.zone;
                countdown_next    = {1'b0, entry_delay} + CNT_W'(1);
                entry_flag_next   = 1'b1;
              end
            end else if (item.reaction == REACT_INSTANT ||
                         item.reaction == REACT_24H) begin
              alarm_flag_next = 1'b1;
              ev_kind         = EV_ALARM;
              ev_src          = item.zone;
            end
          end else if (section_mode == MODE_UNSET) begin
            if (item.reaction == REACT_24H) begin
              alarm_flag_next = 1'b1;
              ev_kind         = EV_ALARM;
              ev_src          = item.zone;
            end
          end
        end
      end
      CMD_ARM: begin
        if (section_mode != MODE_SET) begin
          countdown_next    = {1'b0, exit_delay} + CNT_W'(1);
          exit_flag_next    = 1'b1;
          alarm_flag_next   = 1'b0;
          ev_kind           = EV_SET;
          ev_src            = ZONE_W'(item.access_source);
          section_mode_next = MODE_SET;
          changed           = 1'b1;
        end
      end
      CMD_DISARM: begin
        // exit flag kept as is
        if (section_mode != MODE_UNSET) begin
          entry_flag_next   = 1'b0;
          alarm_flag_next   = 1'b0;
          countdown_next    = '0;
          ev_kind           = EV_UNSET;
          ev_src            = ZONE_W'(item.access_source);
          section_mode_next = MODE_UNSET;
          changed           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per stepped beat
  always_ff @(posedge clk) begin
    if (rst) begin
      section_mode <= MODE_UNKNOWN;
      alarm_flag   <= 1'b0;
      exit_flag    <= 1'b0;
      entry_flag   <= 1'b0;
      countdown    <= '0;
      pending_zone <= '0;
    end else if (step) begin
      section_mode <= section_mode_next;
      alarm_flag   <= alarm_flag_next;
      exit_flag    <= exit_flag_next;
      entry_flag   <= entry_flag_next;
      countdown    <= countdown_next;
      pending_zone <= pending_zone_next;
    end
  end

  assign result.event_kind         = ev_kind;
  assign result.event_source       = ev_src;
  assign result.mode_changed       = changed;
  assign result.may_alarm          = may_alarm;
  assign result.mode               = section_mode_next;
  assign result.alarm_active       = alarm_flag_next;
  assign result.exit_delay_active  = exit_flag_next;
  assign result.entry_delay_active = entry_flag_next;

endmodule : asac_core

`default_nettype wire

// ===== hdl/alarm_section_arming_controller_unit.sv =====
// ----------------------------------------------------------------------------
// alarm_section_arming_controller_unit
// Arming controller for one intrusion-alarm section, streaming interface.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands (tick, zone signal, arm, disarm); each beat gives
//   exactly one result beat on m_axis, in order. cfg_we/cfg_index/cfg_data
//   write the exit delay (index 0) and entry delay (index 1); write only while
//   the block is idle.
// Path: the input register holds a beat, then one step of the section logic
//   feeds its result into the output register.
// Throughput: one beat per cycle while m_axis_tready is high; the section state
//   is registered at each step, so back-to-back beats see each other's effect.
// Reset: rst (synchronous) puts the section in the unknown mode with all
//   flags and the delay timer clear, and both delay registers at 30 ticks;
//   a delay of N expires on tick N+1. Stall: while m_axis_tready is low the
//   result holds; one more beat is taken into the input register, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_section_arming_controller_unit #(
  parameter int ZONE_COUNT = 64,
  parameter int DELAY_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // cmd[1:0], zone[7:2], reaction[9:8], access_source[13:10], zero[15:14]
  input  wire logic [asac_pkg::TDATA_W-1:0]   s_axis_tdata,
  // master stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // event_kind[1:0], event_source[7:2], mode_changed[8], may_alarm[9],
  // mode[11:10], alarm_active[12], exit_delay_active[13],
  // entry_delay_active[14], zero[15]
  output logic [asac_pkg::TDATA_W-1:0]        m_axis_tdata,
  // configuration write
  input  wire logic                           cfg_we,
  input  wire logic [asac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [asac_pkg::CFG_W-1:0]     cfg_data
);
  import asac_pkg::*;

  logic      in_valid;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  out_item_t step_result;
  logic      advance;
  cfg_wr_t   cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Handshake: input stage moves on when the output stage is free
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    end
  end

  asac_core #(
    .ZONE_COUNT (ZONE_COUNT),
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (in_item),
    .result (step_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'(out_item);

  // A full input stage must not be overwritten while the output is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_axis_tready |-> !s_axis_tready)
    else $error("input stage accepted a beat while blocked");

  // An accepted mode change always reports an arm or disarm event
  a_change_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.mode_changed |->
      (out_item.event_kind == EV_SET || out_item.event_kind == EV_UNSET))
    else $error("mode change without arm or disarm event");

  // Disarm leaves no alarm and no entry delay behind
  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.event_kind == EV_UNSET |->
      (!out_item.alarm_active && !out_item.entry_delay_active &&
       out_item.mode == MODE_UNSET))
    else $error("disarm did not clear alarm or entry delay");

endmodule : alarm_section_arming_controller_unit

`default_nettype wire
